[rtl/pfdr_pkg.sv]
// shared types and constants for the page frame buffer with dirty refresh
// no dependencies; used by controller, datapath, top level and checker
package pfdr_pkg;

    localparam int DEF_SCREEN_WIDTH  = 128;
    localparam int DEF_SCREEN_HEIGHT = 32;
    localparam int MAX_RESULTS       = 64;

    localparam logic OP_FILL  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // configuration register index (byte address bit 2)
    localparam logic REG_DISPLAY_READY = 1'b0;

    typedef enum logic [1:0] {
        KIND_DONE   = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_PAGE   = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_RUN,
        S_FRD,
        S_FWR,
        S_XRD,
        S_XOUT,
        S_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic  capture;
        logic  dec_fill;
        logic  dec_find;
        logic  run;
        logic  rd;
        logic  wr;
        logic  adv_fill;
        logic  adv_flush;
        logic  load_out;
        t_kind kind;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic op;
        logic reject;
        logic any_dirty;
        logic row_last;
        logic page_last;
        logic word_last;
    } t_dp_sts;

endpackage

[rtl/pfdr_ctrl.sv]
// command sequencer for the page frame buffer: decode, fill and flush walks
// depends on pfdr_pkg; drives pfdr_dp through t_dp_cmd
module pfdr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  logic              i_display_ready,
    input  pfdr_pkg::t_dp_sts i_sts,
    output pfdr_pkg::t_dp_cmd o_cmd
);
    import pfdr_pkg::*;

    t_state r_state, n_state;
    t_kind  r_resp_kind, n_resp_kind;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_ready;
    assign o_ready   = (r_state == S_IDLE);
    assign o_valid   = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_resp_kind <= KIND_DONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_resp_kind <= n_resp_kind;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_resp_kind = r_resp_kind;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd       = '0;
        o_cmd.kind  = KIND_PAGE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                if (!i_display_ready || (i_sts.op == OP_FILL && i_sts.reject)) begin
                    n_resp_kind = KIND_REJECT;
                    n_state     = S_RESP;
                end else if (i_sts.op == OP_FILL) begin
                    o_cmd.dec_fill = 1'b1;
                    n_state        = S_FRD;
                end else if (!i_sts.any_dirty) begin
                    n_resp_kind = KIND_NONE;
                    n_state     = S_RESP;
                end else begin
                    o_cmd.dec_find = 1'b1;
                    n_state        = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.run = 1'b1;
                n_state   = S_XRD;
            end
            S_FRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_FWR;
            end
            S_FWR: begin
                o_cmd.wr = 1'b1;
                if (i_sts.row_last && i_sts.page_last) begin
                    n_resp_kind = KIND_DONE;
                    n_state     = S_RESP;
                end else begin
                    o_cmd.adv_fill = 1'b1;
                    n_state        = S_FRD;
                end
            end
            S_XRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_XOUT;
            end
            S_XOUT: begin
                // one word a cycle while the output side keeps up
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.kind     = KIND_PAGE;
                    n_out_valid    = 1'b1;
                    if (i_sts.word_last && i_sts.page_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.adv_flush = 1'b1;
                        o_cmd.rd        = 1'b1;
                    end
                end
            end
            S_RESP: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.kind     = r_resp_kind;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/pfdr_dp.sv]
// datapath: command registers, frame store rows, dirty mask, page pointer
// and the result register; depends on pfdr_pkg, steered by pfdr_ctrl
module pfdr_dp #(
    parameter int SCREEN_WIDTH  = pfdr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = pfdr_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfdr_pkg::t_dp_cmd i_cmd,
    output pfdr_pkg::t_dp_sts o_sts,
    input  logic              i_op,
    input  logic [7:0]        i_left_x,
    input  logic [7:0]        i_top_y,
    input  logic [7:0]        i_right_x,
    input  logic [7:0]        i_bottom_y,
    input  logic              i_set_pixels,
    output logic [1:0]        o_kind,
    output logic [1:0]        o_page_index,
    output logic [3:0]        o_word_index,
    output logic [63:0]       o_pixel_word,
    output logic              o_last,
    output logic              o_still_dirty
);
    import pfdr_pkg::*;

    localparam int PAGES  = (SCREEN_HEIGHT + 7) / 8;
    localparam int WORDS  = (SCREEN_WIDTH + 7) / 8;
    localparam int PBITS  = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int WBITS  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int ABITS  = PBITS + WBITS;
    localparam int DEPTH  = 1 << ABITS;
    localparam int LIMIT0 = MAX_RESULTS / WORDS;
    localparam int LIMIT  = (LIMIT0 == 0) ? 1 : LIMIT0;
    localparam logic [7:0]       W_MAX  = 8'(SCREEN_WIDTH - 1);
    localparam logic [7:0]       H_MAX  = 8'(SCREEN_HEIGHT - 1);
    localparam logic [WBITS-1:0] W_LAST = WBITS'(WORDS - 1);
    localparam logic [PBITS-1:0] P_LAST = PBITS'(PAGES - 1);

    // captured command
    logic       r_op;
    logic [7:0] r_left, r_top, r_right, r_bottom;
    logic       r_set;

    logic [PAGES-1:0] r_dirty;
    logic [PBITS-1:0] r_next_page;
    logic [PBITS-1:0] r_page, r_end_page;
    logic [WBITS-1:0] r_word;

    // frame store, one row holds eight column bytes of one page
    logic [63:0]      mem [DEPTH];
    logic [DEPTH-1:0] r_row_vld;
    logic [63:0]      r_rd_data;
    logic             r_rd_vld;

    logic [1:0]  r_kind;
    logic [1:0]  r_page_out;
    logic [3:0]  r_word_out;
    logic [63:0] r_pix_out;
    logic        r_last_out;
    logic        r_still_out;

    logic [7:0]       rc, bc;
    logic [WBITS-1:0] w_start, w_end;
    logic [PBITS-1:0] fill_sp, fill_ep;
    logic [PBITS-1:0] nx_page, find_page, run_ep, run_next;
    logic [WBITS-1:0] nx_word;
    logic [ABITS-1:0] cur_addr, rd_addr;
    logic [63:0]      old_row, new_row;
    logic [7:0]       row_mask;

    assign rc      = (r_right > W_MAX) ? W_MAX : r_right;
    assign bc      = (r_bottom > H_MAX) ? H_MAX : r_bottom;
    assign w_start = WBITS'(r_left >> 3);
    assign w_end   = WBITS'(rc >> 3);
    assign fill_sp = PBITS'(r_top >> 3);
    assign fill_ep = PBITS'(bc >> 3);

    assign o_sts.op        = r_op;
    assign o_sts.reject    = (r_left > W_MAX) || (r_top > H_MAX) ||
                             (r_left > r_right) || (r_top > r_bottom);
    assign o_sts.any_dirty = |r_dirty;
    assign o_sts.row_last  = (r_word == w_end);
    assign o_sts.page_last = (r_page == r_end_page);
    assign o_sts.word_last = (r_word == W_LAST);

    // next row of a walk
    always_comb begin
        nx_page = r_page;
        nx_word = r_word + 1'b1;
        if (i_cmd.adv_fill && r_word == w_end) begin
            nx_page = r_page + 1'b1;
            nx_word = w_start;
        end else if (i_cmd.adv_flush && r_word == W_LAST) begin
            nx_page = r_page + 1'b1;
            nx_word = '0;
        end
    end

    assign cur_addr = {r_page, r_word};
    assign rd_addr  = i_cmd.adv_flush ? {nx_page, nx_word} : cur_addr;

    // first dirty page at or after the pointer, cyclically
    always_comb begin
        logic [PBITS:0] idx;
        find_page = '0;
        for (int i = PAGES - 1; i >= 0; i--) begin
            idx = {1'b0, r_next_page} + (PBITS + 1)'(i);
            if (idx >= (PBITS + 1)'(PAGES)) begin
                idx = idx - (PBITS + 1)'(PAGES);
            end
            if (r_dirty[idx[PBITS-1:0]]) begin
                find_page = idx[PBITS-1:0];
            end
        end
    end

    // end of the dirty run, upward without wrap and within the word budget
    always_comb begin
        logic [PBITS:0] idx;
        logic [PBITS:0] n;
        logic           grow;
        run_ep = r_page;
        n      = (PBITS + 1)'(1);
        grow   = 1'b1;
        for (int j = 1; j < PAGES; j++) begin
            idx = {1'b0, r_page} + (PBITS + 1)'(j);
            if (grow && idx < (PBITS + 1)'(PAGES) && r_dirty[idx[PBITS-1:0]] &&
                int'(n) < LIMIT) begin
                run_ep = idx[PBITS-1:0];
                n      = n + 1'b1;
            end else begin
                grow = 1'b0;
            end
        end
        run_next = (run_ep == P_LAST) ? '0 : run_ep + 1'b1;
    end

    // read-modify-write of one row for a fill
    always_comb begin
        logic [2:0] tb, bb;
        logic [7:0] colv, m, b;
        tb       = (r_page == fill_sp) ? r_top[2:0] : 3'd0;
        bb       = (r_page == r_end_page) ? bc[2:0] : 3'd7;
        row_mask = (8'hFF << tb) & (8'hFF >> (3'd7 - bb));
        old_row  = r_rd_vld ? r_rd_data : 64'd0;
        new_row  = old_row;
        for (int c = 0; c < 8; c++) begin
            colv = 8'({r_word, 3'(c)});
            m    = (colv >= r_left && colv <= rc) ? row_mask : 8'd0;
            b    = old_row[8*c +: 8];
            new_row[8*c +: 8] = r_set ? (b | m) : (b & ~m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_op;
            r_left   <= i_left_x;
            r_top    <= i_top_y;
            r_right  <= i_right_x;
            r_bottom <= i_bottom_y;
            r_set    <= i_set_pixels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty     <= {PAGES{1'b1}};
            r_next_page <= '0;
        end else if (i_cmd.dec_fill) begin
            for (int p = 0; p < PAGES; p++) begin
                if (PBITS'(p) >= fill_sp && PBITS'(p) <= fill_ep) begin
                    r_dirty[p] <= 1'b1;
                end
            end
        end else if (i_cmd.run) begin
            for (int p = 0; p < PAGES; p++) begin
                if (PBITS'(p) >= r_page && PBITS'(p) <= run_ep) begin
                    r_dirty[p] <= 1'b0;
                end
            end
            r_next_page <= run_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dec_fill) begin
            r_page     <= fill_sp;
            r_end_page <= fill_ep;
            r_word     <= w_start;
        end else if (i_cmd.dec_find) begin
            r_page <= find_page;
        end else if (i_cmd.run) begin
            r_end_page <= run_ep;
            r_word     <= '0;
        end else if (i_cmd.adv_fill || i_cmd.adv_flush) begin
            r_page <= nx_page;
            r_word <= nx_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[cur_addr] <= new_row;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // rows never written read as a cleared screen
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_cmd.wr) begin
                r_row_vld[cur_addr] <= 1'b1;
            end
            if (i_cmd.rd) begin
                r_rd_vld <= r_row_vld[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_kind <= i_cmd.kind;
            if (i_cmd.kind == KIND_PAGE) begin
                r_page_out  <= 2'(r_page);
                r_word_out  <= 4'(r_word);
                r_pix_out   <= r_rd_vld ? r_rd_data : 64'd0;
                r_last_out  <= (r_page == r_end_page) && (r_word == W_LAST);
                r_still_out <= |r_dirty;
            end else begin
                r_page_out  <= '0;
                r_word_out  <= '0;
                r_pix_out   <= '0;
                r_last_out  <= 1'b1;
                r_still_out <= 1'b0;
            end
        end
    end

    assign o_kind        = r_kind;
    assign o_page_index  = r_page_out;
    assign o_word_index  = r_word_out;
    assign o_pixel_word  = r_pix_out;
    assign o_last        = r_last_out;
    assign o_still_dirty = r_still_out;

endmodule

[rtl/page_framebuffer_fill_dirty_refresh_top.sv]
// top level of the page frame buffer with dirty-page refresh
// depends on pfdr_pkg, pfdr_ctrl and pfdr_dp; holds the register port
//
//  channel   direction  handshake            payload
//  command   in         i_valid / o_ready    i_op, i_left_x, i_top_y, i_right_x,
//                                            i_bottom_y, i_set_pixels
//  result    out        o_valid / i_ready    o_kind, o_page_index, o_word_index,
//                                            o_pixel_word, o_last, o_still_dirty
//  register  in/out     psel/penable/pready  paddr, pwdata, prdata
//
// one command at a time: accept, decode, then the walk
// fill: each eight-column row is read, then written back, in the frame store
// flush: decode, find the run and read the first word, then one page word per
// cycle while the result side keeps up, 64 words at most
// a stalled result holds a flush walk; reset clears the row valid bits,
// marks every page dirty and needs no clearing pass
module page_framebuffer_fill_dirty_refresh_top #(
    parameter int SCREEN_WIDTH  = pfdr_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = pfdr_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_left_x,
    input  logic [7:0]  i_top_y,
    input  logic [7:0]  i_right_x,
    input  logic [7:0]  i_bottom_y,
    input  logic        i_set_pixels,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_page_index,
    output logic [3:0]  o_word_index,
    output logic [63:0] o_pixel_word,
    output logic        o_last,
    output logic        o_still_dirty,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pfdr_pkg::*;

    logic    r_display_ready;
    t_dp_cmd cmd;
    t_dp_sts sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_ready <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == REG_DISPLAY_READY) begin
            r_display_ready <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_DISPLAY_READY) ? {31'd0, r_display_ready} : 32'd0;

    pfdr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .i_display_ready (r_display_ready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    pfdr_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_op),
        .i_left_x      (i_left_x),
        .i_top_y       (i_top_y),
        .i_right_x     (i_right_x),
        .i_bottom_y    (i_bottom_y),
        .i_set_pixels  (i_set_pixels),
        .o_kind        (o_kind),
        .o_page_index  (o_page_index),
        .o_word_index  (o_word_index),
        .o_pixel_word  (o_pixel_word),
        .o_last        (o_last),
        .o_still_dirty (o_still_dirty)
    );

endmodule

[rtl/pfdr_chk.sv]
// port-level checks for the page frame buffer top level
// depends on pfdr_pkg; attached to the top level by the bind below
module pfdr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_kind,
    input logic [1:0]  o_page_index,
    input logic [3:0]  o_word_index,
    input logic [63:0] o_pixel_word,
    input logic        o_last,
    input logic        o_still_dirty,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);
    import pfdr_pkg::*;

    // a waiting result item holds its kind, word index, pixel word and last mark
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_pixel_word) &&
        $stable(o_word_index) && $stable(o_last))
        else $error("result item changed while stalled");

    // single results carry only their kind and the last mark
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_PAGE |-> o_last && o_page_index == 2'd0 &&
        o_word_index == 4'd0 && o_pixel_word == 64'd0 && !o_still_dirty)
        else $error("non-data result with stray fields");

    // one command at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item taken while busy");

    // register write is visible on read back
    a_reg_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && paddr[2] == REG_DISPLAY_READY |=>
        paddr[2] != REG_DISPLAY_READY || prdata[0] == $past(pwdata[0]))
        else $error("display ready read back mismatch");

endmodule

bind page_framebuffer_fill_dirty_refresh_top pfdr_chk u_chk (.*);

[tb/sv/pfdr_page_checker.sv]
// checker for the page frame buffer: watches the command, result and register ports,
// keeps its own copy of the image, dirty pages and flush pointer, and compares each result
// depends on pfdr_pkg for the screen size, result budget, kind codes, command codes and register index
module pfdr_page_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic        i_op,
    input  logic [7:0]  i_left_x,
    input  logic [7:0]  i_top_y,
    input  logic [7:0]  i_right_x,
    input  logic [7:0]  i_bottom_y,
    input  logic        i_set_pixels,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [1:0]  i_kind,
    input  logic [1:0]  i_page_index,
    input  logic [3:0]  i_word_index,
    input  logic [63:0] i_pixel_word,
    input  logic        i_last,
    input  logic        i_still_dirty,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending
);
    import pfdr_pkg::*;

    localparam int WIDTH     = DEF_SCREEN_WIDTH;
    localparam int HEIGHT    = DEF_SCREEN_HEIGHT;
    localparam int PAGES     = (HEIGHT + 7) / 8;
    localparam int WORDS     = (WIDTH + 7) / 8;
    localparam int RUN_PAGES = (MAX_RESULTS / WORDS > 0) ? MAX_RESULTS / WORDS : 1;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  page;
        logic [3:0]  word;
        logic [63:0] pixels;
        logic        last;
        logic        still;
    } t_page_result;

    logic [7:0]       image [PAGES][WIDTH];
    logic [PAGES-1:0] dirty_pages;
    int               flush_from;
    logic             display_on;
    t_page_result     due_results [$];
    int               errors = 0;
    int               pending_count = 0;

    assign o_errors  = errors;
    assign o_pending = pending_count;

    function automatic t_page_result short_result(t_kind kind);
        t_page_result res;
        res        = '0;
        res.kind   = kind;
        res.last   = 1'b1;
        return res;
    endfunction

    task automatic fill_rect(logic [7:0] lx, logic [7:0] ty, logic [7:0] rx, logic [7:0] by,
                             logic set_px);
        int rcol, brow, first_pg, last_pg, top_bit, bot_bit;
        logic [7:0] mask;
        if (lx >= WIDTH || ty >= HEIGHT || lx > rx || ty > by) begin
            due_results.push_back(short_result(KIND_REJECT));
            return;
        end
        rcol     = (rx >= WIDTH) ? WIDTH - 1 : rx;
        brow     = (by >= HEIGHT) ? HEIGHT - 1 : by;
        first_pg = ty / 8;
        last_pg  = brow / 8;
        for (int p = first_pg; p <= last_pg; p++) begin
            top_bit = (p == first_pg) ? ty % 8 : 0;
            bot_bit = (p == last_pg) ? brow % 8 : 7;
            mask    = (8'hFF << top_bit) & (8'hFF >> (7 - bot_bit));
            for (int x = lx; x <= rcol; x++) begin
                if (set_px) begin
                    image[p][x] = image[p][x] | mask;
                end else begin
                    image[p][x] = image[p][x] & ~mask;
                end
            end
            dirty_pages[p] = 1'b1;
        end
        due_results.push_back(short_result(KIND_DONE));
    endtask

    task automatic flush_run();
        int first_pg, last_pg, run_len, col;
        t_page_result res;
        if (dirty_pages == '0) begin
            due_results.push_back(short_result(KIND_NONE));
            return;
        end
        first_pg = 0;
        for (int i = PAGES - 1; i >= 0; i--) begin
            // walking down keeps the nearest dirty page at or after the pointer
            if (dirty_pages[(flush_from + i) % PAGES]) first_pg = (flush_from + i) % PAGES;
        end
        last_pg = first_pg;
        run_len = 1;
        while (last_pg + 1 < PAGES && dirty_pages[last_pg + 1] && run_len < RUN_PAGES) begin
            last_pg++;
            run_len++;
        end
        for (int p = first_pg; p <= last_pg; p++) dirty_pages[p] = 1'b0;
        flush_from = (last_pg + 1) % PAGES;
        for (int p = first_pg; p <= last_pg; p++) begin
            for (int w = 0; w < WORDS; w++) begin
                res        = '0;
                res.kind   = KIND_PAGE;
                res.page   = 2'(p);
                res.word   = 4'(w);
                for (int c = 0; c < 8; c++) begin
                    col = w * 8 + c;
                    if (col < WIDTH) res.pixels[c*8 +: 8] = image[p][col];
                end
                res.last   = (p == last_pg && w == WORDS - 1);
                res.still  = (dirty_pages != '0);
                due_results.push_back(res);
            end
        end
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    task automatic check_result();
        t_page_result want;
        if (due_results.size() == 0) begin
            $error("result with nothing expected: kind %0d page %0d word %0d",
                   i_kind, i_page_index, i_word_index);
            errors++;
            return;
        end
        want = due_results.pop_front();
        check_field("kind", want.kind, i_kind);
        check_field("page_index", want.page, i_page_index);
        check_field("word_index", want.word, i_word_index);
        check_field("pixel_word", want.pixels, i_pixel_word);
        check_field("last", want.last, i_last);
        check_field("still_dirty", want.still, i_still_dirty);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PAGES; p++) begin
                for (int x = 0; x < WIDTH; x++) image[p][x] = 8'h00;
            end
            dirty_pages = '1;
            flush_from  = 0;
            display_on  = 1'b0;
            due_results.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_DISPLAY_READY) begin
                display_on = pwdata[0];
            end
            if (i_cmd_valid && i_cmd_ready) begin
                if (!display_on) begin
                    due_results.push_back(short_result(KIND_REJECT));
                end else if (i_op == OP_FILL) begin
                    fill_rect(i_left_x, i_top_y, i_right_x, i_bottom_y, i_set_pixels);
                end else begin
                    flush_run();
                end
            end
            if (i_res_valid && i_res_ready) check_result();
        end
        pending_count <= due_results.size();
    end

endmodule

[tb/sv/page_framebuffer_fill_dirty_refresh_top_test.sv]
// stimulus and verdict for the page frame buffer with dirty-page refresh
// depends on pfdr_pkg, the block's top level and pfdr_page_checker
module page_framebuffer_fill_dirty_refresh_top_test;
    import pfdr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT        = 330;

    typedef struct packed {
        logic       op;
        logic [7:0] left_x;
        logic [7:0] top_y;
        logic [7:0] right_x;
        logic [7:0] bottom_y;
        logic       set_pixels;
    } t_command;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_ready;
    logic        i_op         = 1'b0;
    logic [7:0]  i_left_x     = 8'h00;
    logic [7:0]  i_top_y      = 8'h00;
    logic [7:0]  i_right_x    = 8'h00;
    logic [7:0]  i_bottom_y   = 8'h00;
    logic        i_set_pixels = 1'b0;
    logic        o_valid;
    logic        i_ready      = 1'b0;
    logic [1:0]  o_kind;
    logic [1:0]  o_page_index;
    logic [3:0]  o_word_index;
    logic [63:0] o_pixel_word;
    logic        o_last;
    logic        o_still_dirty;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = 3'd0;
    logic [31:0] pwdata       = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending_count;
    int cmds_sent = 0;
    bit calm      = 1'b0;

    page_framebuffer_fill_dirty_refresh_top i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_op, .i_left_x, .i_top_y, .i_right_x, .i_bottom_y, .i_set_pixels,
        .o_valid, .i_ready,
        .o_kind, .o_page_index, .o_word_index, .o_pixel_word, .o_last, .o_still_dirty,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    pfdr_page_checker i_checker (
        .i_clk, .i_rst_n,
        .i_cmd_valid(i_valid), .i_cmd_ready(o_ready),
        .i_op, .i_left_x, .i_top_y, .i_right_x, .i_bottom_y, .i_set_pixels,
        .i_res_valid(o_valid), .i_res_ready(i_ready),
        .i_kind(o_kind), .i_page_index(o_page_index), .i_word_index(o_word_index),
        .i_pixel_word(o_pixel_word), .i_last(o_last), .i_still_dirty(o_still_dirty),
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_errors(fail_count), .o_pending(pending_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // mostly back to back, sometimes a short idle, now and then a long pause
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_command make_cmd(logic op, int lx, int ty, int rx, int by, logic set_px);
        t_command c;
        c.op         = op;
        c.left_x     = 8'(lx);
        c.top_y      = 8'(ty);
        c.right_x    = 8'(rx);
        c.bottom_y   = 8'(by);
        c.set_pixels = set_px;
        return c;
    endfunction

    // mostly sane rectangles and flushes, the rest arbitrary noise
    function automatic t_command rand_command();
        int pick;
        t_command c;
        pick = $urandom_range(0, 99);
        c = make_cmd(OP_FILL, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
        if (pick < 30) begin
            c.op = OP_FLUSH;
        end else if (pick < 88) begin
            c.left_x   = 8'($urandom_range(0, 127));
            c.right_x  = (pick < 80) ? 8'(c.left_x + $urandom_range(0, 24)) : 8'hFF;
            c.top_y    = 8'($urandom_range(0, 31));
            c.bottom_y = (pick < 84) ? 8'(c.top_y + $urandom_range(0, 12))
                                     : 8'($urandom_range(c.top_y, 255));
        end
        return c;
    endfunction

    // entered and left on a rising edge
    task automatic send(t_command c);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_op         <= c.op;
        i_left_x     <= c.left_x;
        i_top_y      <= c.top_y;
        i_right_x    <= c.right_x;
        i_bottom_y   <= c.bottom_y;
        i_set_pixels <= c.set_pixels;
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        cmds_sent++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_display_ready(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DISPLAY_READY, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_random(int count, int calm_from, int calm_to);
        for (int n = 0; n < count; n++) begin
            calm = (n >= calm_from && n < calm_to);
            send(rand_command());
        end
        calm = 1'b0;
    endtask

    // result side: random stalls plus one long hold-off to back the block up
    initial begin
        int stall_left;
        int hold_left;
        bit held;
        stall_left = 0;
        hold_left  = 0;
        held       = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && cmds_sent >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready    <= 1'b1;
                stall_left = calm ? 0 : idle_len();
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // display not yet up: everything is turned away
        send(make_cmd(OP_FILL, 0, 0, 10, 10, 1'b1));
        send(make_cmd(OP_FLUSH, 0, 0, 0, 0, 1'b0));
        settle();
        write_display_ready(32'd1);

        // every page starts dirty, so the first flush walks the whole screen
        send(make_cmd(OP_FLUSH, 0, 0, 0, 0, 1'b0));
        send(make_cmd(OP_FLUSH, 0, 0, 0, 0, 1'b0));
        send(make_cmd(OP_FILL, 0, 0, 255, 255, 1'b1));
        send(make_cmd(OP_FILL, 5, 3, 20, 12, 1'b0));
        send(make_cmd(OP_FILL, 127, 31, 127, 31, 1'b0));
        send(make_cmd(OP_FILL, 0, 0, 0, 0, 1'b0));
        send(make_cmd(OP_FLUSH, 0, 0, 0, 0, 1'b0));
        // off-screen corners and reversed corners
        send(make_cmd(OP_FILL, 128, 0, 130, 5, 1'b1));
        send(make_cmd(OP_FILL, 0, 32, 5, 40, 1'b1));
        send(make_cmd(OP_FILL, 10, 0, 9, 5, 1'b1));
        send(make_cmd(OP_FILL, 0, 10, 5, 9, 1'b1));
        send(make_cmd(OP_FILL, 255, 255, 255, 255, 1'b1));
        // scattered dirty pages: single-page and two-page runs, no wrap past the last page
        send(make_cmd(OP_FILL, 0, 16, 127, 23, 1'b0));
        send(make_cmd(OP_FILL, 3, 0, 3, 7, 1'b1));
        send(make_cmd(OP_FLUSH, 0, 0, 0, 0, 1'b0));
        send(make_cmd(OP_FLUSH, 0, 0, 0, 0, 1'b0));
        send(make_cmd(OP_FILL, 64, 24, 200, 31, 1'b0));
        send(make_cmd(OP_FILL, 0, 7, 127, 8, 1'b0));
        send(make_cmd(OP_FLUSH, 0, 0, 0, 0, 1'b0));
        send(make_cmd(OP_FLUSH, 0, 0, 0, 0, 1'b0));
        send(make_cmd(OP_FLUSH, 255, 255, 255, 255, 1'b1));
        send(make_cmd(OP_FILL, 0, 0, 127, 31, 1'b0));
        send(make_cmd(OP_FLUSH, 0, 0, 0, 0, 1'b0));

        send_random(200, 60, 100);
        settle();
        write_display_ready(32'd0);
        send_random(15, 0, 0);
        settle();
        write_display_ready(32'd1);
        send_random(180, 150, 180);

        settle();
        if (fail_count == 0 && pending_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[page_framebuffer_fill_dirty_refresh_top.f]
rtl/pfdr_pkg.sv
rtl/pfdr_ctrl.sv
rtl/pfdr_dp.sv
rtl/page_framebuffer_fill_dirty_refresh_top.sv
rtl/pfdr_chk.sv
tb/sv/pfdr_page_checker.sv
tb/sv/page_framebuffer_fill_dirty_refresh_top_test.sv
